>>> rtl/rfbcmp_pkg.sv
// Package for the remote-framebuffer client message parser.
// Message codes, lengths, parser phases and the event word type.
// No dependencies.
`default_nettype none

package rfbcmp_pkg;

	// client message type bytes
	localparam logic [7:0] MT_SET_PIXEL_FORMAT = 8'd0;
	localparam logic [7:0] MT_SET_ENCODINGS    = 8'd2;
	localparam logic [7:0] MT_UPDATE_REQ       = 8'd3;
	localparam logic [7:0] MT_KEY_EVENT        = 8'd4;
	localparam logic [7:0] MT_POINTER_EVENT    = 8'd5;

	// body lengths in bytes (after the type byte)
	localparam int PIXFMT_LEN  = 19;
	localparam int UPDATE_LEN  = 9;
	localparam int KEY_LEN     = 8;
	localparam int POINTER_LEN = 5;

	// remaining-byte counter covers count*4 of a 16-bit count
	localparam int LEFT_W = 18;
	// deepest history needed before the last byte of a gathered body
	localparam int HIST_D = UPDATE_LEN - 1;

	// event kinds
	localparam logic [1:0] EK_UPDATE  = 2'd0;
	localparam logic [1:0] EK_KEY     = 2'd1;
	localparam logic [1:0] EK_POINTER = 2'd2;
	localparam logic [1:0] EK_ERROR   = 2'd3;

	// configuration register indexes
	localparam logic REG_PARSER_ENABLED = 1'b0;
	localparam int   PADDR_W            = 3;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_SKIP,
		PH_ENC_PAD,
		PH_ENC_HI,
		PH_ENC_LO,
		PH_GATHER,
		PH_HALT
	} phase_t;

	typedef struct packed {
		logic [1:0]  event_kind;
		logic [15:0] pos_x;
		logic [15:0] pos_y;
		logic [15:0] rect_width;
		logic [15:0] rect_height;
		logic        incremental;
		logic [31:0] key_code;
		logic        key_down;
		logic [7:0]  button_mask;
		logic [7:0]  bad_type;
	} evt_t;

endpackage

`default_nettype wire

>>> rtl/rfbcmp_byte_if.sv
// Byte channel: valid/ready handshake carrying one client byte per word.
// No dependencies.
`default_nettype none

interface rfbcmp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

`default_nettype wire

>>> rtl/rfbcmp_event_if.sv
// Event channel: valid/ready handshake carrying one decoded message per word.
// No dependencies.
`default_nettype none

interface rfbcmp_event_if;
	logic        valid;
	logic        ready;
	logic [1:0]  event_kind;
	logic [15:0] pos_x;
	logic [15:0] pos_y;
	logic [15:0] rect_width;
	logic [15:0] rect_height;
	logic        incremental;
	logic [31:0] key_code;
	logic        key_down;
	logic [7:0]  button_mask;
	logic [7:0]  bad_type;

	modport source (
		output valid, output event_kind, output pos_x, output pos_y,
		output rect_width, output rect_height, output incremental,
		output key_code, output key_down, output button_mask,
		output bad_type, input ready
	);
	modport sink (
		input valid, input event_kind, input pos_x, input pos_y,
		input rect_width, input rect_height, input incremental,
		input key_code, input key_down, input button_mask,
		input bad_type, output ready
	);
endinterface

`default_nettype wire

>>> rtl/rfbcmp_fsm.sv
// Parser state machine: phase, counters, byte history and event build.
// Depends on rfbcmp_pkg.
`default_nettype none

module rfbcmp_fsm
	import rfbcmp_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire logic [7:0] data_byte,
	output logic            res_valid,
	output evt_t            res
);

	phase_t              phase_q, phase_d;
	logic [1:0]          kind_q, kind_d;
	logic [LEFT_W-1:0]   left_q, left_d;
	logic [7:0]          cnt_hi_q, cnt_hi_d;
	logic [7:0]          hist_q [HIST_D];
	logic [LEFT_W-1:0]   left_dec;
	logic [LEFT_W-1:0]   enc_bytes;

	assign left_dec  = left_q - LEFT_W'(1);
	assign enc_bytes = {cnt_hi_q, data_byte, 2'b00};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			kind_q   <= EK_UPDATE;
			left_q   <= '0;
			cnt_hi_q <= '0;
		end else if (step) begin
			phase_q  <= phase_d;
			kind_q   <= kind_d;
			left_q   <= left_d;
			cnt_hi_q <= cnt_hi_d;
		end
	end

	// history of the gathered body, newest in entry 0
	always_ff @(posedge clk) begin
		if (step && phase_q == PH_GATHER) begin
			hist_q[0] <= data_byte;
			for (int k = 1; k < HIST_D; k++) begin
				hist_q[k] <= hist_q[k-1];
			end
		end
	end

	always_comb begin
		phase_d   = phase_q;
		kind_d    = kind_q;
		left_d    = left_q;
		cnt_hi_d  = cnt_hi_q;
		res_valid = 1'b0;
		res       = '0;
		unique case (phase_q)
			PH_IDLE: begin
				case (data_byte) inside
					MT_SET_PIXEL_FORMAT: begin
						left_d  = LEFT_W'(PIXFMT_LEN);
						phase_d = PH_SKIP;
					end
					MT_SET_ENCODINGS: begin
						phase_d = PH_ENC_PAD;
					end
					MT_UPDATE_REQ: begin
						kind_d  = EK_UPDATE;
						left_d  = LEFT_W'(UPDATE_LEN);
						phase_d = PH_GATHER;
					end
					MT_KEY_EVENT: begin
						kind_d  = EK_KEY;
						left_d  = LEFT_W'(KEY_LEN);
						phase_d = PH_GATHER;
					end
					MT_POINTER_EVENT: begin
						kind_d  = EK_POINTER;
						left_d  = LEFT_W'(POINTER_LEN);
						phase_d = PH_GATHER;
					end
					default: begin
						res_valid      = 1'b1;
						res.event_kind = EK_ERROR;
						res.bad_type   = data_byte;
						phase_d        = PH_HALT;
					end
				endcase
			end
			PH_SKIP: begin
				left_d = left_dec;
				if (left_dec == '0) begin
					phase_d = PH_IDLE;
				end
			end
			PH_ENC_PAD: begin
				phase_d = PH_ENC_HI;
			end
			PH_ENC_HI: begin
				cnt_hi_d = data_byte;
				phase_d  = PH_ENC_LO;
			end
			PH_ENC_LO: begin
				left_d  = enc_bytes;
				phase_d = (enc_bytes == '0) ? PH_IDLE : PH_SKIP;
			end
			PH_GATHER: begin
				left_d = left_dec;
				if (left_dec == '0) begin
					phase_d        = PH_IDLE;
					res_valid      = 1'b1;
					res.event_kind = kind_q;
					case (kind_q)
						EK_UPDATE: begin
							res.pos_x       = {hist_q[7], hist_q[6]};
							res.pos_y       = {hist_q[5], hist_q[4]};
							res.rect_width  = {hist_q[3], hist_q[2]};
							res.rect_height = {hist_q[1], hist_q[0]};
							res.incremental = (data_byte != 8'd0);
						end
						EK_KEY: begin
							res.key_down = (hist_q[6] != 8'd0);
							res.key_code = {hist_q[2], hist_q[1], hist_q[0], data_byte};
						end
						default: begin
							res.pos_x       = {hist_q[3], hist_q[2]};
							res.pos_y       = {hist_q[1], hist_q[0]};
							res.button_mask = data_byte;
						end
					endcase
				end
			end
			PH_HALT: begin
				phase_d = PH_HALT;
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase
	end

	a_res_needs_step: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && step |-> phase_q == PH_IDLE || phase_q == PH_GATHER)
		else $error("event built outside idle or gather");

	a_halt_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_HALT |=> phase_q == PH_HALT)
		else $error("left halt without reset");

	a_error_halts: assert property (@(posedge clk) disable iff (!arst_n)
		step && res_valid && res.event_kind == EK_ERROR |=> phase_q == PH_HALT)
		else $error("error word did not halt the parser");

	a_gather_kind: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_GATHER |-> kind_q != EK_ERROR && left_q != '0)
		else $error("gather phase with bad kind or empty count");

endmodule

`default_nettype wire

>>> rtl/rfb_client_message_parser_top.sv
// Top level of the remote-framebuffer client message parser.
// Depends on rfbcmp_pkg, rfbcmp_byte_if, rfbcmp_event_if, rfbcmp_fsm.
`default_nettype none

// Channel   Dir   Word                     Accepted when
// rx        in    one client byte          rx.valid && rx.ready
// evt       out   one decoded message      evt.valid && evt.ready
// apb       in    parser_enabled register  psel && penable && pwrite
//
// One byte per cycle unless a held event waits; the event of a message's
// last byte is registered and shows on evt the cycle after that byte is taken.
// rx.ready drops only while a held event is not taken (one output stage).
// Reset puts the parser idle and disabled; enable it by writing bit 0.
// An unknown message type gives one error word, then the parser drops all
// bytes until reset.
module rfb_client_message_parser_top
	import rfbcmp_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	rfbcmp_byte_if.sink             rx,
	rfbcmp_event_if.source          evt,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [31:0]        pwdata,
	output logic      [31:0]        prdata,
	output logic                    pready
);

	logic  enabled_q;
	logic  rx_fire;
	logic  reg_hit;
	logic  res_valid;
	evt_t  res;
	logic  evt_valid_q;
	evt_t  evt_q;

	// config port: one register, at every word with the top address bit clear
	assign pready  = 1'b1;
	assign reg_hit = (paddr[PADDR_W-1] == REG_PARSER_ENABLED);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q <= 1'b0;
		end else if (psel && penable && pwrite && reg_hit) begin
			enabled_q <= pwdata[0];
		end
	end

	assign prdata = reg_hit ? {31'd0, enabled_q} : 32'd0;

	// input side stalls only when the output word is still held
	assign rx.ready = !evt_valid_q || evt.ready;
	assign rx_fire  = rx.valid && rx.ready;

	// bytes taken while disabled are dropped without touching parser state
	rfbcmp_fsm u_fsm (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (rx_fire && enabled_q),
		.data_byte (rx.data_byte),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			evt_valid_q <= 1'b0;
		end else if (rx_fire) begin
			evt_valid_q <= res_valid && enabled_q;
		end else if (evt.ready) begin
			evt_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_fire) begin
			evt_q <= res;
		end
	end

	assign evt.valid       = evt_valid_q;
	assign evt.event_kind  = evt_q.event_kind;
	assign evt.pos_x       = evt_q.pos_x;
	assign evt.pos_y       = evt_q.pos_y;
	assign evt.rect_width  = evt_q.rect_width;
	assign evt.rect_height = evt_q.rect_height;
	assign evt.incremental = evt_q.incremental;
	assign evt.key_code    = evt_q.key_code;
	assign evt.key_down    = evt_q.key_down;
	assign evt.button_mask = evt_q.button_mask;
	assign evt.bad_type    = evt_q.bad_type;

	a_disabled_no_event: assert property (@(posedge clk) disable iff (!arst_n)
		rx_fire && !enabled_q |=> !evt.valid)
		else $error("event produced while parser disabled");

	a_event_from_byte: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(evt_valid_q) && evt_valid_q |-> $past(rx_fire))
		else $error("event word appeared without a byte");

	a_error_fields: assert property (@(posedge clk) disable iff (!arst_n)
		evt.valid && evt.event_kind != EK_ERROR |-> evt.bad_type == 8'd0)
		else $error("bad_type set on a non-error word");

endmodule

`default_nettype wire
